>>> rtl/annealing_acceptance_with_cooling_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANNEALING_ACCEPTANCE_WITH_COOLING_UNIT_ASSERT_SVH
`define ANNEALING_ACCEPTANCE_WITH_COOLING_UNIT_ASSERT_SVH

// property that must hold at every edge
`define AAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/aac_pkg.sv
// ----------------------------------------------------------------------------
// aac_pkg
// Widths, register indexes, datapath operation codes and link structs.
// ----------------------------------------------------------------------------
package aac_pkg;

   localparam int FITNESS_WIDTH_DEF = 32;
   localparam int PROB_BITS_DEF     = 16;

   localparam int GEN_W      = 24;
   localparam int DRAW_W     = 16;
   localparam int TEMP_W     = 32;
   localparam int RATE_W     = 16;
   localparam int PER_W      = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // result transfer: accept, temperature_now, second_phase
   localparam int RSP_FIELDS_W = 1 + TEMP_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Q1.30 series arithmetic
   localparam int QW        = 31;
   localparam int Q_FRAC    = 30;
   localparam int SUM_W     = 32;
   localparam int K_W       = 5;
   localparam int CNT_W     = 5;
   localparam int EXP_SHIFT = 14;
   localparam logic [QW-1:0]    Q30_ONE      = QW'(1) << Q_FRAC;
   localparam logic [K_W-1:0]   SERIES_TERMS = K_W'(16);
   localparam logic [CNT_W-1:0] N_MAX        = CNT_W'(24);
   localparam int HUNDRED = 100;

   // reset values
   localparam logic [TEMP_W-1:0] START_TEMP_RST = TEMP_W'(65536);
   localparam logic [TEMP_W-1:0] TRANS_TEMP_RST = TEMP_W'(32768);
   localparam logic [RATE_W-1:0] RATE1_RST      = RATE_W'(52429);
   localparam logic [RATE_W-1:0] RATE2_RST      = RATE_W'(62259);
   localparam logic [PER_W-1:0]  PER_RST        = PER_W'(1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_TEMP = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_TEMP = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RATE1      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RATE2      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_PER        = CSR_IDX_W'(4);

   // datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE   = OP_W'(0);
   localparam logic [OP_W-1:0] OP_LOAD   = OP_W'(1);
   localparam logic [OP_W-1:0] OP_GDIV   = OP_W'(2);
   localparam logic [OP_W-1:0] OP_MULT   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_COOL   = OP_W'(4);
   localparam logic [OP_W-1:0] OP_DIFF   = OP_W'(5);
   localparam logic [OP_W-1:0] OP_CMP    = OP_W'(6);
   localparam logic [OP_W-1:0] OP_XDIV   = OP_W'(7);
   localparam logic [OP_W-1:0] OP_XSAVE  = OP_W'(8);
   localparam logic [OP_W-1:0] OP_EMUL   = OP_W'(9);
   localparam logic [OP_W-1:0] OP_EDIV   = OP_W'(10);
   localparam logic [OP_W-1:0] OP_ESTEP  = OP_W'(11);
   localparam logic [OP_W-1:0] OP_EEND   = OP_W'(12);
   localparam logic [OP_W-1:0] OP_QMUL   = OP_W'(13);
   localparam logic [OP_W-1:0] OP_QSTEP  = OP_W'(14);
   localparam logic [OP_W-1:0] OP_PDIV   = OP_W'(15);
   localparam logic [OP_W-1:0] OP_DECIDE = OP_W'(16);
   localparam logic [OP_W-1:0] OP_OUT    = OP_W'(17);

   typedef struct packed {
      logic [OP_W-1:0] op;
   } aac_cmd_type;

   typedef struct packed {
      logic div_done;
      logic is_tour;
      logic rem_zero;
      logic out_range;
      logic n_big;
      logic series;
      logic k_last;
      logic cnt_zero;
   } aac_stat_type;

endpackage

>>> rtl/annealing_acceptance_with_cooling_unit.sv
// ----------------------------------------------------------------------------
// annealing_acceptance_with_cooling_unit
// Simulated-annealing acceptance with a two-phase geometric cooling schedule.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser: kind; tdata: gen, parent, child, draw
//  rsp      out  rsp_tvalid/rsp_tready  tdata: accept, temperature_now, second_phase
//  csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
//  One item at a time. The shared restoring divider (DW bits, one per cycle,
//  DW = max(FITNESS_WIDTH+17, PROB_BITS+31, 24), 49 at defaults) does every
//  division of an item. An update item divides the generation by the level
//  length and cools only on a level boundary. An out-of-range tournament
//  ends after the compare; one with n > 24 (n = integer part of |delta|/T)
//  skips the series; others run the series and n multiplies by exp(-1),
//  which the first one after reset builds and keeps.
//  Reset is synchronous and needs no sweep.
//  A finished result waits in the output register; the next item is taken
//  while it stalls, and the unit holds only when a second result is ready.
// ----------------------------------------------------------------------------
module annealing_acceptance_with_cooling_unit
   import aac_pkg::*;
#(
   parameter int FITNESS_WIDTH = FITNESS_WIDTH_DEF,
   parameter int PROB_BITS     = PROB_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,  // [0] req_type
   // generation, parent_fitness, child_fitness, random_draw from bit 0 up
   input  logic [((GEN_W+2*FITNESS_WIDTH+DRAW_W+7)/8)*8-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_TDATA_W-1:0]             rsp_tdata,  // accept, temperature_now, second_phase
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [CSR_IDX_W-1:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]              csr_wdata
);
   // field offsets in req_tdata
   localparam int PAR_LSB  = GEN_W;
   localparam int CHI_LSB  = GEN_W + FITNESS_WIDTH;
   localparam int DRAW_LSB = GEN_W + 2 * FITNESS_WIDTH;

   aac_cmd_type  cmd;
   aac_stat_type stat;
   logic         rsp_accept;
   logic [TEMP_W-1:0] temperature_now;
   logic         second_phase;

   // registers are always writable; software must write only while idle, not enforced here
   assign csr_ready = 1'b1;

   aac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   aac_dp #(
      .FITNESS_WIDTH (FITNESS_WIDTH),
      .PROB_BITS     (PROB_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_tuser),
      .generation      (req_tdata[GEN_W-1:0]),
      .parent_fitness  (req_tdata[PAR_LSB +: FITNESS_WIDTH]),
      .child_fitness   (req_tdata[CHI_LSB +: FITNESS_WIDTH]),
      .random_draw     (req_tdata[DRAW_LSB +: DRAW_W]),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_accept      (rsp_accept),
      .temperature_now (temperature_now),
      .second_phase    (second_phase)
   );

   // pack the result transfer, accept in bit 0
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, second_phase, temperature_now, rsp_accept};
endmodule

>>> rtl/aac_div.sv
// ----------------------------------------------------------------------------
// aac_div
// Restoring divider, one quotient bit per cycle, registered results.
// ----------------------------------------------------------------------------
module aac_div #(
   parameter int DW = 64,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   trial_sub;
   logic          fits;

   assign trial     = {rem_ff, quo_ff[DW-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DW);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? trial_sub[VW-1:0] : trial[VW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> rtl/aac_ctrl.sv
// ----------------------------------------------------------------------------
// aac_ctrl
// Sequencer: steps the datapath through one update or tournament item.
// ----------------------------------------------------------------------------
module aac_ctrl
   import aac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output aac_cmd_type  cmd,
   input  aac_stat_type stat
);
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE  = ST_W'(0);
   localparam logic [ST_W-1:0] S_DISP  = ST_W'(1);
   localparam logic [ST_W-1:0] S_GWAIT = ST_W'(2);
   localparam logic [ST_W-1:0] S_MULT  = ST_W'(3);
   localparam logic [ST_W-1:0] S_COOL  = ST_W'(4);
   localparam logic [ST_W-1:0] S_CMP   = ST_W'(5);
   localparam logic [ST_W-1:0] S_XDIV  = ST_W'(6);
   localparam logic [ST_W-1:0] S_XWAIT = ST_W'(7);
   localparam logic [ST_W-1:0] S_EMUL  = ST_W'(8);
   localparam logic [ST_W-1:0] S_EDIV  = ST_W'(9);
   localparam logic [ST_W-1:0] S_EWAIT = ST_W'(10);
   localparam logic [ST_W-1:0] S_EEND  = ST_W'(11);
   localparam logic [ST_W-1:0] S_QCHK  = ST_W'(12);
   localparam logic [ST_W-1:0] S_QSTEP = ST_W'(13);
   localparam logic [ST_W-1:0] S_PDIV  = ST_W'(14);
   localparam logic [ST_W-1:0] S_PWAIT = ST_W'(15);
   localparam logic [ST_W-1:0] S_DONE  = ST_W'(16);

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.is_tour) begin
               cmd.op   = OP_DIFF;
               state_in = S_CMP;
            end else begin
               cmd.op   = OP_GDIV;
               state_in = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (stat.div_done) begin
               state_in = stat.rem_zero ? S_MULT : S_DONE;
            end
         end
         S_MULT: begin
            cmd.op   = OP_MULT;
            state_in = S_COOL;
         end
         S_COOL: begin
            cmd.op   = OP_COOL;
            state_in = S_DONE;
         end
         S_CMP: begin
            cmd.op   = OP_CMP;
            state_in = stat.out_range ? S_DONE : S_XDIV;
         end
         S_XDIV: begin
            cmd.op   = OP_XDIV;
            state_in = S_XWAIT;
         end
         S_XWAIT: begin
            if (stat.div_done) begin
               cmd.op   = OP_XSAVE;
               state_in = stat.n_big ? S_PDIV : S_EMUL;
            end
         end
         S_EMUL: begin
            cmd.op   = OP_EMUL;
            state_in = S_EDIV;
         end
         S_EDIV: begin
            cmd.op   = OP_EDIV;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (stat.div_done) begin
               cmd.op   = OP_ESTEP;
               state_in = stat.k_last ? S_EEND : S_EMUL;
            end
         end
         S_EEND: begin
            cmd.op   = OP_EEND;
            state_in = stat.series ? S_QCHK : S_EMUL;
         end
         S_QCHK: begin
            if (stat.cnt_zero) begin
               state_in = S_PDIV;
            end else begin
               cmd.op   = OP_QMUL;
               state_in = S_QSTEP;
            end
         end
         S_QSTEP: begin
            cmd.op   = OP_QSTEP;
            state_in = S_QCHK;
         end
         S_PDIV: begin
            cmd.op   = OP_PDIV;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (stat.div_done) begin
               cmd.op   = OP_DECIDE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> rtl/aac_dp.sv
// ----------------------------------------------------------------------------
// aac_dp
// Datapath: registers, state, multiplies, shared divider, result register.
// ----------------------------------------------------------------------------
module aac_dp
   import aac_pkg::*;
#(
   parameter int FITNESS_WIDTH = FITNESS_WIDTH_DEF,
   parameter int PROB_BITS     = PROB_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  aac_cmd_type                     cmd,
   output aac_stat_type                    stat,
   input  logic                            req_kind,
   input  logic [GEN_W-1:0]                generation,
   input  logic signed [FITNESS_WIDTH-1:0] parent_fitness,
   input  logic signed [FITNESS_WIDTH-1:0] child_fitness,
   input  logic [DRAW_W-1:0]               random_draw,
   input  logic                            csr_write,
   input  logic [CSR_IDX_W-1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_wdata,
   output logic                            rsp_accept,
   output logic [TEMP_W-1:0]               temperature_now,
   output logic                            second_phase
);
   localparam int DIFF_W = FITNESS_WIDTH + 1;
   localparam int HUND_W = TEMP_W + 7;
   localparam int CMP_W  = (DIFF_W > HUND_W) ? DIFF_W : HUND_W;
   localparam int XDIV_W = DIFF_W + FRAC_W;
   localparam int PDIV_W = QW + PROB_BITS;
   localparam int DW0    = (XDIV_W > PDIV_W) ? XDIV_W : PDIV_W;
   localparam int DW     = (DW0 > GEN_W) ? DW0 : GEN_W;
   localparam int PROD_W = TEMP_W + QW;
   localparam int DEC_W  = PROB_BITS + DRAW_W + 1;
   localparam int N_W    = DW - FRAC_W;

   // configuration and kept state
   logic [TEMP_W-1:0] trans_ff, trans_in;
   logic [RATE_W-1:0] rate1_ff, rate1_in;
   logic [RATE_W-1:0] rate2_ff, rate2_in;
   logic [PER_W-1:0]  per_ff, per_in;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              phase_ff, phase_in;
   logic              e1_valid_ff, e1_valid_in;
   // item and working registers
   logic                     kind_ff, kind_in;
   logic [GEN_W-1:0]         gen_ff, gen_in;
   logic [FITNESS_WIDTH-1:0] par_ff, par_in;
   logic [FITNESS_WIDTH-1:0] chi_ff, chi_in;
   logic [DRAW_W-1:0]        draw_ff, draw_in;
   logic [DIFF_W-1:0]        mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [HUND_W-1:0]        hund_ff, hund_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic [QW-1:0]            term_ff, term_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [QW-1:0]            r_ff, r_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic                     series_ff, series_in;
   logic [QW-1:0]            e1_ff, e1_in;
   logic [QW-1:0]            q_ff, q_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     acc_ff, acc_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   logic [TEMP_W-1:0]        rsp_temp_ff, rsp_temp_in;
   logic                     rsp_phase_ff, rsp_phase_in;

   logic              div_start;
   logic [DW-1:0]     div_dividend;
   logic [TEMP_W-1:0] div_divisor;
   logic              div_done;
   logic [DW-1:0]     div_q;
   logic [TEMP_W-1:0] div_r;

   logic signed [DIFF_W-1:0] diff;
   logic [TEMP_W-1:0]        cool_t;
   logic [QW-1:0]            series_val;
   logic [QW-1:0]            pnum;
   logic [DEC_W-1:0]         dec_lhs;
   logic [DEC_W-1:0]         dec_rhs;

   aac_div #(.DW(DW), .VW(TEMP_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign diff = $signed({par_ff[FITNESS_WIDTH-1], par_ff})
               - $signed({chi_ff[FITNESS_WIDTH-1], chi_ff});
   assign cool_t = (prod_ff[FRAC_W +: TEMP_W] == '0) ? TEMP_W'(1) : prod_ff[FRAC_W +: TEMP_W];
   assign series_val = sum_ff[SUM_W-1] ? '0 : sum_ff[QW-1:0];
   assign pnum    = neg_ff ? Q30_ONE : q_ff;
   assign dec_lhs = DEC_W'({draw_ff, {PROB_BITS{1'b0}}});
   assign dec_rhs = {div_q[PROB_BITS:0], {DRAW_W{1'b0}}};

   // divider operand select
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = TEMP_W'(1);
      case (cmd.op)
         OP_GDIV: begin
            div_start    = 1'b1;
            div_dividend = DW'(gen_ff);
            div_divisor  = (per_ff == '0) ? TEMP_W'(1) : TEMP_W'(per_ff);
         end
         OP_XDIV: begin
            div_start    = 1'b1;
            div_dividend = DW'({mag_ff, {FRAC_W{1'b0}}});
            div_divisor  = temp_ff;
         end
         OP_EDIV: begin
            div_start    = 1'b1;
            div_dividend = DW'(prod_ff[Q_FRAC +: QW]);
            div_divisor  = TEMP_W'(k_ff);
         end
         OP_PDIV: begin
            div_start    = 1'b1;
            div_dividend = DW'({pnum, {PROB_BITS{1'b0}}});
            div_divisor  = TEMP_W'(Q30_ONE) + TEMP_W'(q_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      trans_in     = trans_ff;
      rate1_in     = rate1_ff;
      rate2_in     = rate2_ff;
      per_in       = per_ff;
      temp_in      = temp_ff;
      rate_in      = rate_ff;
      phase_in     = phase_ff;
      e1_valid_in  = e1_valid_ff;
      kind_in      = kind_ff;
      gen_in       = gen_ff;
      par_in       = par_ff;
      chi_in       = chi_ff;
      draw_in      = draw_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      hund_in      = hund_ff;
      frac_in      = frac_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      series_in    = series_ff;
      e1_in        = e1_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_phase_in = rsp_phase_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_START_TEMP: begin
               temp_in = (csr_wdata == '0) ? TEMP_W'(1) : csr_wdata[TEMP_W-1:0];
            end
            CSR_TRANS_TEMP: trans_in = csr_wdata[TEMP_W-1:0];
            CSR_RATE1: begin
               rate1_in = csr_wdata[RATE_W-1:0];
               if (!phase_ff) rate_in = csr_wdata[RATE_W-1:0];
            end
            CSR_RATE2: begin
               rate2_in = csr_wdata[RATE_W-1:0];
               if (phase_ff) rate_in = csr_wdata[RATE_W-1:0];
            end
            CSR_PER: per_in = csr_wdata[PER_W-1:0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            kind_in = req_kind;
            gen_in  = generation;
            par_in  = parent_fitness;
            chi_in  = child_fitness;
            draw_in = random_draw;
            acc_in  = 1'b0;
         end
         OP_MULT: prod_in = PROD_W'(temp_ff) * PROD_W'(rate_ff);
         OP_COOL: begin
            temp_in = cool_t;
            if (cool_t < trans_ff) begin
               rate_in  = rate2_ff;
               phase_in = 1'b1;
            end
         end
         OP_DIFF: begin
            neg_in  = diff[DIFF_W-1];
            mag_in  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            hund_in = HUND_W'(temp_ff) * HUND_W'(HUNDRED);
         end
         OP_CMP: acc_in = neg_ff;
         OP_XSAVE: begin
            // e^-x = e^-1 ^ n * e^-frac; e^-1 is kept once computed
            frac_in   = div_q[FRAC_W-1:0];
            cnt_in    = div_q[FRAC_W +: CNT_W];
            q_in      = '0;
            series_in = e1_valid_ff;
            r_in      = e1_valid_ff ? QW'({div_q[FRAC_W-1:0], {EXP_SHIFT{1'b0}}}) : Q30_ONE;
            term_in   = Q30_ONE;
            sum_in    = SUM_W'(Q30_ONE);
            k_in      = K_W'(1);
         end
         OP_EMUL: prod_in = PROD_W'(term_ff) * PROD_W'(r_ff);
         OP_ESTEP: begin
            term_in = div_q[QW-1:0];
            sum_in  = k_ff[0] ? sum_ff - $signed(SUM_W'(div_q[QW-1:0]))
                              : sum_ff + $signed(SUM_W'(div_q[QW-1:0]));
            k_in    = k_ff + K_W'(1);
         end
         OP_EEND: begin
            if (!series_ff) begin
               e1_in       = series_val;
               e1_valid_in = 1'b1;
               series_in   = 1'b1;
               r_in        = QW'({frac_ff, {EXP_SHIFT{1'b0}}});
               term_in     = Q30_ONE;
               sum_in      = SUM_W'(Q30_ONE);
               k_in        = K_W'(1);
            end else begin
               q_in = series_val;
            end
         end
         OP_QMUL: prod_in = PROD_W'(q_ff) * PROD_W'(e1_ff);
         OP_QSTEP: begin
            q_in   = prod_ff[Q_FRAC +: QW];
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_DECIDE: acc_in = dec_lhs < dec_rhs;
         OP_OUT: begin
            rsp_acc_in   = acc_ff;
            rsp_temp_in  = temp_ff;
            rsp_phase_in = phase_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff    <= TRANS_TEMP_RST;
         rate1_ff    <= RATE1_RST;
         rate2_ff    <= RATE2_RST;
         per_ff      <= PER_RST;
         temp_ff     <= START_TEMP_RST;
         rate_ff     <= RATE1_RST;
         phase_ff    <= 1'b0;
         e1_valid_ff <= 1'b0;
      end else begin
         trans_ff    <= trans_in;
         rate1_ff    <= rate1_in;
         rate2_ff    <= rate2_in;
         per_ff      <= per_in;
         temp_ff     <= temp_in;
         rate_ff     <= rate_in;
         phase_ff    <= phase_in;
         e1_valid_ff <= e1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      gen_ff       <= gen_in;
      par_ff       <= par_in;
      chi_ff       <= chi_in;
      draw_ff      <= draw_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      hund_ff      <= hund_in;
      frac_ff      <= frac_in;
      term_ff      <= term_in;
      sum_ff       <= sum_in;
      r_ff         <= r_in;
      k_ff         <= k_in;
      series_ff    <= series_in;
      e1_ff        <= e1_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign stat.div_done  = div_done;
   assign stat.is_tour   = kind_ff;
   assign stat.rem_zero  = (div_r == '0);
   assign stat.out_range = CMP_W'(mag_ff) > CMP_W'(hund_ff);
   assign stat.n_big     = div_q[DW-1:FRAC_W] > N_W'(N_MAX);
   assign stat.series    = series_ff;
   assign stat.k_last    = (k_ff == SERIES_TERMS);
   assign stat.cnt_zero  = (cnt_ff == '0);

   assign rsp_accept      = rsp_acc_ff;
   assign temperature_now = rsp_temp_ff;
   assign second_phase    = rsp_phase_ff;
endmodule

>>> rtl/aac_checker.sv
// ----------------------------------------------------------------------------
// aac_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "annealing_acceptance_with_cooling_unit_assert.svh"

module aac_checker
   import aac_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);
   // a stalled result holds
   `AAC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // one item in work at a time
   `AAC_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "req taken while busy")

   // temperature never reaches zero
   `AAC_ASSERT(a_temp_nonzero, rsp_tvalid |-> (rsp_tdata[32:1] != 32'd0), "zero temperature")

   // second phase never reverts
   `AAC_ASSERT_NEXT(a_phase_sticky, rsp_tvalid && rsp_tdata[33], !rsp_tvalid || rsp_tdata[33], "phase reverted")
endmodule

bind annealing_acceptance_with_cooling_unit aac_checker u_aac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/annealing_acceptance_with_cooling_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annealing acceptance checker
// Watches the request, result and register channels, predicts each result
// from its own copy of the cooling state and compares it field by field.
// ----------------------------------------------------------------------------
module annealing_acceptance_with_cooling_unit_checker
   import aac_pkg::*;
#(
   parameter int REQ_W = ((GEN_W + 2*FITNESS_WIDTH_DEF + DRAW_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending
);

   localparam longint ONE_Q30 = 64'sd1 << 30;

   // packed from the top down: second_phase, temperature_now, accept in bit 0
   typedef struct packed {
      logic              phase2;
      logic [TEMP_W-1:0] temp_now;
      logic              accept;
   } outcome_type;

   outcome_type outcome_q[$];

   logic [TEMP_W-1:0] start_temp, trans_temp, temp;
   logic [RATE_W-1:0] rate1, rate2, rate_now;
   logic [PER_W-1:0]  gens_per_level;
   logic              phase2;

   // exp(-r), r in Q2.30, truncated Taylor series
   function automatic longint exp_neg(longint r);
      longint s;
      longint t;
      s = ONE_Q30;
      t = ONE_Q30;
      for (int k = 1; k <= 16; k++) begin
         t = (t * r) >>> 30;
         t = t / k;
         if (k % 2) s -= t;
         else s += t;
      end
      return (s < 0) ? 0 : s;
   endfunction

   function automatic logic child_wins(longint parent, longint child, longint draw);
      longint t, diff, mag, x, n, q, e1, p;
      t    = longint'(temp);
      diff = parent - child;
      if (diff < -100 * t) return 1'b1;
      if (diff > 100 * t) return 1'b0;
      mag = (diff < 0) ? -diff : diff;
      x   = (mag << 16) / t;
      n   = x >> 16;
      if (n > 24) begin
         q = 0;
      end else begin
         q  = exp_neg((x & 65535) << 14);
         e1 = exp_neg(ONE_Q30);
         for (longint i = 0; i < n; i++) q = (q * e1) >>> 30;
      end
      if (diff >= 0) p = (q << PROB_BITS_DEF) / (ONE_Q30 + q);
      else p = (ONE_Q30 << PROB_BITS_DEF) / (ONE_Q30 + q);
      return ((draw << PROB_BITS_DEF) < (p << 16));
   endfunction

   task automatic cool_step(logic [GEN_W-1:0] gen);
      longint per, nt;
      per = (gens_per_level != 0) ? longint'(gens_per_level) : 1;
      if ((longint'(gen) % per) != 0) return;
      nt = (longint'(temp) * longint'(rate_now)) >> 16;
      if (nt == 0) nt = 1;
      temp = nt[TEMP_W-1:0];
      if (temp < trans_temp) begin
         rate_now = rate2;
         phase2   = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want, got;
      logic        wins;
      if (reset) begin
         start_temp     = START_TEMP_RST;
         trans_temp     = TRANS_TEMP_RST;
         rate1          = RATE1_RST;
         rate2          = RATE2_RST;
         gens_per_level = PER_RST;
         temp           = START_TEMP_RST;
         rate_now       = RATE1_RST;
         phase2         = 1'b0;
         outcome_q.delete();
         errors         = 0;
         pending        = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_TEMP: begin
                  start_temp = csr_wdata;
                  temp = (csr_wdata != 0) ? csr_wdata : TEMP_W'(1);
               end
               CSR_TRANS_TEMP: trans_temp = csr_wdata;
               CSR_RATE1: begin
                  rate1 = csr_wdata[RATE_W-1:0];
                  if (!phase2) rate_now = rate1;
               end
               CSR_RATE2: begin
                  rate2 = csr_wdata[RATE_W-1:0];
                  if (phase2) rate_now = rate2;
               end
               CSR_PER: gens_per_level = csr_wdata[PER_W-1:0];
               default: ;
            endcase
         end
         // compare the oldest outcome before queueing a new one
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_FIELDS_W-1:0];
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (got.accept !== want.accept) begin
                  $display("%0t: accept expected %0d actual %0d",
                           $time, want.accept, got.accept);
                  errors++;
               end
               if (got.temp_now !== want.temp_now) begin
                  $display("%0t: temperature expected %h actual %h",
                           $time, want.temp_now, got.temp_now);
                  errors++;
               end
               if (got.phase2 !== want.phase2) begin
                  $display("%0t: second_phase expected %0d actual %0d",
                           $time, want.phase2, got.phase2);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            wins = 1'b0;
            if (req_tuser)
               wins = child_wins(longint'($signed(req_tdata[55:24])),
                                 longint'($signed(req_tdata[87:56])),
                                 longint'(req_tdata[103:88]));
            else
               cool_step(req_tdata[GEN_W-1:0]);
            want.accept   = wins;
            want.temp_now = temp;
            want.phase2   = phase2;
            outcome_q.push_back(want);
         end
         pending = outcome_q.size();
      end
   end

endmodule

>>> tb/sv/annealing_acceptance_with_cooling_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annealing acceptance unit test
// Drives directed and random update and tournament transfers through several
// cooling settings and idle patterns; the checker predicts every result.
// ----------------------------------------------------------------------------
module annealing_acceptance_with_cooling_unit_test;
   import aac_pkg::*;

   localparam int REQ_W = ((GEN_W + 2*FITNESS_WIDTH_DEF + DRAW_W + 7) / 8) * 8;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid, req_tready, req_tuser;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid, rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     errors, pending;

   int tx_idle, rx_idle;      // percent of cycles each side idles
   bit hold_rsp;              // request a long receiver stall
   int cur_per;               // generations per level as last written

   annealing_acceptance_with_cooling_unit u_top (.*);

   annealing_acceptance_with_cooling_unit_checker u_chk (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // hard stop for a hung run
   initial begin
      #400_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle);
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // offer one item, idling first at random; return at the falling edge
   task automatic send_item(logic kind, logic [23:0] gen, logic [31:0] parent,
                            logic [31:0] child, logic [15:0] draw);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {draw, child, parent, gen};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_cooling(logic [31:0] st, logic [31:0] tr, logic [15:0] r1,
                              logic [15:0] r2, logic [15:0] per);
      csr_write(CSR_START_TEMP, st);
      csr_write(CSR_TRANS_TEMP, tr);
      csr_write(CSR_RATE1, r1);
      csr_write(CSR_RATE2, r2);
      csr_write(CSR_PER, per);
      cur_per = (per == 0) ? 1 : per;
   endtask

   task automatic random_item();
      logic [31:0] child, offset;
      logic [23:0] gen;
      logic [15:0] draw;
      int          per;
      if ($urandom_range(0, 99) < 30) begin
         per = cur_per;
         gen = ($urandom_range(0, 9) < 7) ? 24'(per * $urandom_range(0, 16777215 / per))
                                          : 24'($urandom);
         send_item(1'b0, gen, $urandom, $urandom, $urandom);
      end else begin
         child  = $urandom;
         // spread the fitness gap over every magnitude
         offset = $signed($urandom) >>> $urandom_range(0, 31);
         case ($urandom_range(0, 7))
            0:       draw = 16'h0000;
            1:       draw = 16'hFFFF;
            default: draw = $urandom;
         endcase
         if ($urandom_range(0, 9) == 0) send_item(1'b1, $urandom, $urandom, child, draw);
         else send_item(1'b1, $urandom, child + offset, child, draw);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      hold_rsp   = 1'b0;
      tx_idle    = 0;
      rx_idle    = 0;
      cur_per    = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, temperature 1.0
      tx_idle = 15;
      rx_idle = 79;
      send_item(1'b1, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'h0000); // huge loss
      send_item(1'b1, 24'h0, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);      // huge gain
      send_item(1'b1, 24'h0, 32'h00001234, 32'h00001234, 16'h7FFF);      // even odds
      send_item(1'b1, 24'h0, 32'h00001234, 32'h00001234, 16'h8000);
      send_item(1'b1, 24'h0, 32'd6553600, 32'd0, 16'h0000);              // gap at +100 T
      send_item(1'b1, 24'h0, 32'd6553601, 32'd0, 16'h0000);
      send_item(1'b1, 24'h0, 32'd0, 32'd6553600, 16'hFFFF);              // gap at -100 T
      send_item(1'b1, 24'h0, 32'd0, 32'd6553601, 16'hFFFF);
      send_item(1'b1, 24'h0, 32'd1638400, 32'd0, 16'h0000);              // delta 25
      send_item(1'b1, 24'h0, 32'd1638399, 32'd0, 16'h0000);              // delta under 25
      send_item(1'b1, 24'h0, 32'd65535, 32'd0, 16'h4000);
      send_item(1'b1, 24'h0, 32'd0, 32'd100000, 16'hC000);
      send_item(1'b0, 24'h0, '0, '0, '0);                                 // cool
      send_item(1'b0, 24'hFFFFFF, '1, '1, '1);
      send_item(1'b0, 24'h000003, '0, '0, '0);
      send_item(1'b0, 24'h000004, '0, '0, '0);                            // enters phase two
      send_item(1'b1, 24'h0, 32'hFFFFFFFF, 32'h00000001, 16'h1000);
      drain();

      csr_write(CSR_IDX_W'(5), 32'hDEADBEEF);   // unused indexes do nothing
      csr_write(CSR_IDX_W'(7), 32'h0);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_cooling(32'hFFFFFFFF, 32'd1, 16'hFFFF, 16'h0000, 16'd1);
            1: set_cooling(32'd0, 32'hFFFFFFFF, 16'h0000, 16'hFFFF, 16'd0);
            2: set_cooling(32'd524288, 32'd65536, 16'd52429, 16'd62259, 16'd3);
            3: set_cooling(32'd1 << 20, 32'd1 << 16, 16'd60000, 16'd65000, 16'hFFFF);
            default: set_cooling($urandom_range(1, 1 << 26), $urandom_range(1, 1 << 22),
                                 $urandom, $urandom, $urandom_range(1, 4));
         endcase
         case (ph / 2)
            0: begin tx_idle = 15; rx_idle = 79; end
            1: begin tx_idle = 79; rx_idle = 15; end
            default: begin tx_idle = 0; rx_idle = 0; end
         endcase
         for (int i = 0; i < 300; i++) begin
            // phase 2: stall the receiver long enough to back up the input
            if (ph == 2 && i == 20) hold_rsp = 1'b1;
            if (ph == 4 && i == 150) drain();
            // phase 5: a rate write mid-run while idle
            if (ph == 5 && i == 100) begin
               drain();
               csr_write(CSR_RATE2, $urandom);
               csr_write(CSR_RATE1, $urandom);
            end
            random_item();
         end
         drain();
      end

      repeat (100) @(negedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
